// ----- src/dbc_pkg.sv -----
`default_nettype none

package dbc_pkg;

  localparam int unsigned DRIVES_DEF = 8;
  localparam int unsigned MAP_W      = 16;
  localparam int unsigned STAGES     = 7;

  localparam int unsigned DRV_W   = 3;
  localparam int unsigned PART_W  = 3;
  localparam int unsigned BLK_W   = 20;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned CCYL_W  = 16;
  localparam int unsigned LOOK_W  = 16;
  localparam int unsigned CUR_W   = 10;
  localparam int unsigned PBLK_W  = 19;
  localparam int unsigned NBLK_W  = 8;
  localparam int unsigned CYL_W   = 10;
  localparam int unsigned QUO_W   = 13;
  localparam int unsigned CYLS_W  = 14;
  localparam int unsigned TRK_W   = 5;
  localparam int unsigned SEC_W   = 5;
  localparam int unsigned NS_W    = 6;
  localparam int unsigned PC_W    = 10;
  localparam int unsigned DIST_W  = 5;

  // reciprocal constants: quotient estimate is (x * RCP) >> SH, low by at most one
  localparam int unsigned R1_SH = 30;
  localparam int unsigned R1_W  = 23;
  localparam int unsigned R2_SH = 16;
  localparam int unsigned R2_W  = 12;

  localparam int unsigned NS_A = 22;
  localparam int unsigned NS_B = 32;
  localparam int unsigned NS_C = 32;
  localparam int unsigned PC_A = 22 * 19;
  localparam int unsigned PC_B = 32 * 5;
  localparam int unsigned PC_C = 32 * 19;
  localparam int unsigned RCP1_A = (2**R1_SH) / PC_A;
  localparam int unsigned RCP1_B = (2**R1_SH) / PC_B;
  localparam int unsigned RCP1_C = (2**R1_SH) / PC_C;
  localparam int unsigned RCP2_A = (2**R2_SH) / NS_A;
  localparam int unsigned RCP2_B = (2**R2_SH) / NS_B;
  localparam int unsigned RCP2_C = (2**R2_SH) / NS_C;

  localparam logic [DIST_W-1:0] SDIST_RST  = 5'd2;
  localparam logic [DIST_W-1:0] MARGIN_RST = 5'd3;

  typedef enum logic [1:0] {DT_NONE, DT_A, DT_B, DT_C} dtype_e;
  typedef enum logic [1:0] {ST_OK, ST_BAD_TYPE, ST_PAST_END} status_e;
  typedef enum logic [1:0] {ACT_NONE, ACT_SEARCH, ACT_SEEK} action_e;
  typedef enum logic [1:0] {
    CFG_TYPE_MAP, CFG_SEEK_ONLY, CFG_SEARCH_DIST, CFG_ROT_MARGIN
  } cfg_idx_e;

  typedef struct packed {
    status_e             status;
    dtype_e              dtype;
    logic [BLK_W-1:0]    blk;
    logic [CYL_W-1:0]    base;
    logic [CCYL_W-1:0]   cur_cyl;
    logic [CUR_W-1:0]    cur_sec;
    logic                online;
  } chk_t;

  typedef struct packed {
    status_e             status;
    dtype_e              dtype;
    logic [CYLS_W-1:0]   cyl;
    logic [TRK_W-1:0]    trk;
    logic [SEC_W-1:0]    sec;
    logic [CCYL_W-1:0]   cur_cyl;
    logic [CUR_W-1:0]    cur_sec;
    logic                online;
  } chs_t;

  function automatic logic [NS_W-1:0] geo_ns(input dtype_e dt);
    logic [NS_W-1:0] r;
    unique case (dt)
      DT_A:    r = NS_W'(NS_A);
      DT_B:    r = NS_W'(NS_B);
      DT_C:    r = NS_W'(NS_C);
      DT_NONE: r = NS_W'(NS_C);
    endcase
    return r;
  endfunction

  function automatic logic [PC_W-1:0] geo_pc(input dtype_e dt);
    logic [PC_W-1:0] r;
    unique case (dt)
      DT_A:    r = PC_W'(PC_A);
      DT_B:    r = PC_W'(PC_B);
      DT_C:    r = PC_W'(PC_C);
      DT_NONE: r = PC_W'(PC_C);
    endcase
    return r;
  endfunction

  function automatic logic [R1_W-1:0] rcp_pc(input dtype_e dt);
    logic [R1_W-1:0] r;
    unique case (dt)
      DT_A:    r = R1_W'(RCP1_A);
      DT_B:    r = R1_W'(RCP1_B);
      DT_C:    r = R1_W'(RCP1_C);
      DT_NONE: r = R1_W'(RCP1_C);
    endcase
    return r;
  endfunction

  function automatic logic [R2_W-1:0] rcp_ns(input dtype_e dt);
    logic [R2_W-1:0] r;
    unique case (dt)
      DT_A:    r = R2_W'(RCP2_A);
      DT_B:    r = R2_W'(RCP2_B);
      DT_C:    r = R2_W'(RCP2_C);
      DT_NONE: r = R2_W'(RCP2_C);
    endcase
    return r;
  endfunction

  // partition ROM: size in blocks
  function automatic logic [PBLK_W-1:0] part_blocks(input dtype_e dt,
                                                    input logic [PART_W-1:0] p);
    logic [PBLK_W-1:0] r;
    r = '0;
    unique case (dt)
      DT_A: begin
        unique case (p)
          3'd0:    r = 19'd15884;
          3'd1:    r = 19'd33440;
          3'd2:    r = 19'd340670;
          3'd6:    r = 19'd291346;
          default: r = '0;
        endcase
      end
      DT_B: begin
        unique case (p)
          3'd0:    r = 19'd15884;
          3'd1:    r = 19'd33440;
          3'd2:    r = 19'd131680;
          3'd6:    r = 19'd82080;
          default: r = '0;
        endcase
      end
      DT_C: begin
        unique case (p)
          3'd0: r = 19'd15884;
          3'd1: r = 19'd33440;
          3'd2: r = 19'd500992;
          3'd3: r = 19'd15884;
          3'd4: r = 19'd55936;
          3'd5: r = 19'd86944;
          3'd6: r = 19'd159296;
          3'd7: r = 19'd291346;
        endcase
      end
      DT_NONE: r = '0;
    endcase
    return r;
  endfunction

  // partition ROM: starting cylinder
  function automatic logic [CYL_W-1:0] part_base(input dtype_e dt,
                                                 input logic [PART_W-1:0] p);
    logic [CYL_W-1:0] r;
    r = '0;
    unique case (dt)
      DT_A: begin
        unique case (p)
          3'd1:    r = 10'd38;
          3'd6:    r = 10'd118;
          default: r = '0;
        endcase
      end
      DT_B: begin
        unique case (p)
          3'd1:    r = 10'd100;
          3'd6:    r = 10'd310;
          default: r = '0;
        endcase
      end
      DT_C: begin
        unique case (p)
          3'd1:    r = 10'd27;
          3'd3:    r = 10'd562;
          3'd4:    r = 10'd589;
          3'd5:    r = 10'd681;
          3'd6:    r = 10'd562;
          3'd7:    r = 10'd82;
          default: r = '0;
        endcase
      end
      DT_NONE: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/dbc_check.sv -----
`default_nettype none

// Stage 1: drive type, partition lookup, end-of-partition check.
module dbc_check #(
  parameter int unsigned DRIVES = dbc_pkg::DRIVES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [2*DRIVES-1:0]          type_map_i,
  input  wire logic [dbc_pkg::DRV_W-1:0]    drive_unit_i,
  input  wire logic [dbc_pkg::PART_W-1:0]   partition_i,
  input  wire logic [dbc_pkg::BLK_W-1:0]    block_number_i,
  input  wire logic [dbc_pkg::BYTES_W-1:0]  byte_count_i,
  input  wire logic [dbc_pkg::CCYL_W-1:0]   current_cylinder_i,
  input  wire logic [dbc_pkg::LOOK_W-1:0]   lookahead_raw_i,
  input  wire logic                         drive_online_i,
  output dbc_pkg::chk_t                     chk_o
);

  logic [2*DRIVES-1:0]          map_sh;
  dbc_pkg::dtype_e              dtype;
  logic [dbc_pkg::BYTES_W:0]    bytes_up;
  logic [dbc_pkg::NBLK_W-1:0]   nblk;
  logic [dbc_pkg::BLK_W:0]      blk_end;
  logic                         past_end;
  dbc_pkg::chk_t                chk_d, chk_q;

  always_comb begin
    map_sh = type_map_i >> {drive_unit_i, 1'b0};
    if ({1'b0, drive_unit_i} < 4'(DRIVES)) begin
      dtype = dbc_pkg::dtype_e'(map_sh[1:0]);
    end else begin
      dtype = dbc_pkg::DT_NONE;
    end
    // round bytes up to whole blocks
    bytes_up = (dbc_pkg::BYTES_W+1)'(byte_count_i) + (dbc_pkg::BYTES_W+1)'(511);
    nblk     = bytes_up[dbc_pkg::BYTES_W -: dbc_pkg::NBLK_W];
    blk_end  = (dbc_pkg::BLK_W+1)'(block_number_i) + (dbc_pkg::BLK_W+1)'(nblk);
    past_end = blk_end > (dbc_pkg::BLK_W+1)'(dbc_pkg::part_blocks(dtype, partition_i));

    chk_d.dtype   = dtype;
    chk_d.blk     = block_number_i;
    chk_d.base    = dbc_pkg::part_base(dtype, partition_i);
    chk_d.cur_cyl = current_cylinder_i;
    chk_d.cur_sec = lookahead_raw_i[dbc_pkg::LOOK_W-1 -: dbc_pkg::CUR_W];
    chk_d.online  = drive_online_i;
    priority if (dtype == dbc_pkg::DT_NONE) begin
      chk_d.status = dbc_pkg::ST_BAD_TYPE;
    end else if (past_end) begin
      chk_d.status = dbc_pkg::ST_PAST_END;
    end else begin
      chk_d.status = dbc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chk_q <= chk_d;
    end
  end

  assign chk_o = chk_q;

endmodule

`default_nettype wire

// ----- src/dbc_chs.sv -----
`default_nettype none

// Stages 2-5: block -> cylinder, track, sector by reciprocal multiply and
// one correction step per division.
module dbc_chs (
  input  wire logic          clk_i,
  input  wire logic [3:0]    en_i,
  input  dbc_pkg::chk_t      chk_i,
  output dbc_pkg::chs_t      chs_o
);

  localparam int unsigned P1_W = dbc_pkg::BLK_W + dbc_pkg::R1_W;
  localparam int unsigned QD_W = dbc_pkg::QUO_W + dbc_pkg::PC_W;
  localparam int unsigned RR_W = dbc_pkg::PC_W + 1;
  localparam int unsigned P2_W = dbc_pkg::PC_W + dbc_pkg::R2_W;
  localparam int unsigned TN_W = dbc_pkg::TRK_W + dbc_pkg::NS_W;
  localparam int unsigned SR_W = dbc_pkg::NS_W + 1;

  // stage 2: quotient estimate
  logic [P1_W-1:0]                 prod1;
  dbc_pkg::chk_t                   s2_q;
  logic [dbc_pkg::QUO_W-1:0]       qest_q;

  // stage 3: corrected quotient and remainder
  logic [dbc_pkg::PC_W-1:0]        pc3;
  logic [QD_W-1:0]                 qd;
  logic [dbc_pkg::BLK_W-1:0]       rdiff;
  logic [RR_W-1:0]                 rem_raw;
  logic                            fix3;
  dbc_pkg::chk_t                   s3_q;
  logic [dbc_pkg::QUO_W-1:0]       quo_q;
  logic [dbc_pkg::PC_W-1:0]        rem_q;

  // stage 4: cylinder sum and track estimate
  logic [P2_W-1:0]                 prod2;
  dbc_pkg::chs_t                   s4_d, s4_q;
  logic [dbc_pkg::PC_W-1:0]        rem4_q;

  // stage 5: track and sector
  logic [dbc_pkg::NS_W-1:0]        ns5;
  logic [TN_W-1:0]                 tn;
  logic [dbc_pkg::PC_W-1:0]        sdiff;
  logic [SR_W-1:0]                 sec_raw;
  logic                            fix5;
  dbc_pkg::chs_t                   s5_d, s5_q;

  always_comb begin
    prod1 = P1_W'(chk_i.blk) * P1_W'(dbc_pkg::rcp_pc(chk_i.dtype));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s2_q   <= chk_i;
      qest_q <= prod1[dbc_pkg::R1_SH +: dbc_pkg::QUO_W];
    end
  end

  always_comb begin
    pc3     = dbc_pkg::geo_pc(s2_q.dtype);
    qd      = QD_W'(qest_q) * QD_W'(pc3);
    rdiff   = s2_q.blk - qd[dbc_pkg::BLK_W-1:0];
    rem_raw = rdiff[RR_W-1:0];
    fix3    = rem_raw >= RR_W'(pc3);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s3_q  <= s2_q;
      quo_q <= qest_q + dbc_pkg::QUO_W'(fix3);
      rem_q <= fix3 ? dbc_pkg::PC_W'(rem_raw - RR_W'(pc3)) : dbc_pkg::PC_W'(rem_raw);
    end
  end

  always_comb begin
    prod2        = P2_W'(rem_q) * P2_W'(dbc_pkg::rcp_ns(s3_q.dtype));
    s4_d.status  = s3_q.status;
    s4_d.dtype   = s3_q.dtype;
    s4_d.cyl     = dbc_pkg::CYLS_W'(quo_q) + dbc_pkg::CYLS_W'(s3_q.base);
    s4_d.trk     = prod2[dbc_pkg::R2_SH +: dbc_pkg::TRK_W];
    s4_d.sec     = '0;
    s4_d.cur_cyl = s3_q.cur_cyl;
    s4_d.cur_sec = s3_q.cur_sec;
    s4_d.online  = s3_q.online;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s4_q   <= s4_d;
      rem4_q <= rem_q;
    end
  end

  always_comb begin
    ns5     = dbc_pkg::geo_ns(s4_q.dtype);
    tn      = TN_W'(s4_q.trk) * TN_W'(ns5);
    sdiff   = rem4_q - dbc_pkg::PC_W'(tn);
    sec_raw = sdiff[SR_W-1:0];
    fix5    = sec_raw >= SR_W'(ns5);
    s5_d     = s4_q;
    s5_d.trk = s4_q.trk + dbc_pkg::TRK_W'(fix5);
    s5_d.sec = fix5 ? dbc_pkg::SEC_W'(sec_raw - SR_W'(ns5)) : dbc_pkg::SEC_W'(sec_raw);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s5_q <= s5_d;
    end
  end

  assign chs_o = s5_q;

endmodule

`default_nettype wire

// ----- src/dbc_position.sv -----
`default_nettype none

// Stages 6-7: search sector, positioning decision, result register.
module dbc_position (
  input  wire logic                          clk_i,
  input  wire logic [1:0]                    en_i,
  input  dbc_pkg::chs_t                      chs_i,
  input  wire logic                          seek_only_i,
  input  wire logic [dbc_pkg::DIST_W-1:0]    search_distance_i,
  input  wire logic [dbc_pkg::DIST_W-1:0]    rotation_margin_i,
  output logic [1:0]                         status_o,
  output logic [dbc_pkg::CYL_W-1:0]          cylinder_o,
  output logic [dbc_pkg::TRK_W-1:0]          track_o,
  output logic [dbc_pkg::SEC_W-1:0]          sector_o,
  output logic [dbc_pkg::SEC_W-1:0]          search_sector_o,
  output logic [1:0]                         position_action_o
);

  localparam int unsigned T_W  = dbc_pkg::NS_W + 1;
  localparam int unsigned SL_W = dbc_pkg::CUR_W + 2;

  typedef struct packed {
    dbc_pkg::status_e            status;
    dbc_pkg::dtype_e             dtype;
    logic [dbc_pkg::CYL_W-1:0]   cyl;
    logic [dbc_pkg::TRK_W-1:0]   trk;
    logic [dbc_pkg::SEC_W-1:0]   sec;
    logic [dbc_pkg::SEC_W-1:0]   ssec;
    logic                        cyl_ne;
    logic [dbc_pkg::CUR_W-1:0]   cur_sec;
    logic                        online;
  } pos_t;

  logic [dbc_pkg::NS_W-1:0]   ns6, sdm;
  logic [T_W-1:0]             tsum, tmod;
  pos_t                       s6_d, s6_q;

  logic [dbc_pkg::NS_W-1:0]   ns7;
  logic signed [SL_W-1:0]     slack, slack_w, limit;
  dbc_pkg::action_e           act;

  // stage 6
  always_comb begin
    ns6  = dbc_pkg::geo_ns(chs_i.dtype);
    sdm  = (dbc_pkg::NS_W'(search_distance_i) >= ns6) ?
           dbc_pkg::NS_W'(search_distance_i) - ns6 : dbc_pkg::NS_W'(search_distance_i);
    tsum = T_W'(chs_i.sec) + T_W'(ns6) - T_W'(sdm);
    tmod = (tsum >= T_W'(ns6)) ? tsum - T_W'(ns6) : tsum;

    s6_d.status  = chs_i.status;
    s6_d.dtype   = chs_i.dtype;
    s6_d.cyl     = chs_i.cyl[dbc_pkg::CYL_W-1:0];
    s6_d.trk     = chs_i.trk;
    s6_d.sec     = chs_i.sec;
    s6_d.ssec    = tmod[dbc_pkg::SEC_W-1:0];
    s6_d.cyl_ne  = dbc_pkg::CCYL_W'(chs_i.cyl) != chs_i.cur_cyl;
    s6_d.cur_sec = chs_i.cur_sec;
    s6_d.online  = chs_i.online;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s6_q <= s6_d;
    end
  end

  // stage 7: rotational slack
  always_comb begin
    ns7     = dbc_pkg::geo_ns(s6_q.dtype);
    slack   = $signed(SL_W'(s6_q.cur_sec)) - $signed(SL_W'(s6_q.ssec)) + SL_W'(1);
    slack_w = (slack < 0) ? slack + $signed(SL_W'(ns7)) : slack;
    limit   = $signed(SL_W'(ns7)) - $signed(SL_W'(rotation_margin_i));
    priority if (!s6_q.online) begin
      act = dbc_pkg::ACT_NONE;
    end else if (s6_q.cyl_ne) begin
      act = seek_only_i ? dbc_pkg::ACT_SEEK : dbc_pkg::ACT_SEARCH;
    end else if (seek_only_i) begin
      act = dbc_pkg::ACT_NONE;
    end else if (slack_w > limit) begin
      act = dbc_pkg::ACT_NONE;
    end else begin
      act = dbc_pkg::ACT_SEARCH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      status_o <= s6_q.status;
      if (s6_q.status == dbc_pkg::ST_OK) begin
        cylinder_o        <= s6_q.cyl;
        track_o           <= s6_q.trk;
        sector_o          <= s6_q.sec;
        search_sector_o   <= s6_q.ssec;
        position_action_o <= act;
      end else begin
        cylinder_o        <= '0;
        track_o           <= '0;
        sector_o          <= '0;
        search_sector_o   <= '0;
        position_action_o <= dbc_pkg::ACT_NONE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/disk_block_to_chs_mapper_top.sv -----
`default_nettype none

// Disk block to cylinder/track/sector mapper. One request beat in, one
// result beat out, in order. Requests are checked against the drive type
// (2 bits per drive in the type map) and the type's partition ROM, then the
// block is split into cylinder, track and sector, a search target sector
// is formed and a positioning action chosen. Rate: one beat per cycle
// while the output is not stalled. There are seven register stages
// (check, two stages per reciprocal division, search sector, result
// register), and the check stage loads at the accepting edge itself.
// Holes in the pipe close up under output stall, so input stall rises
// only when all seven stages hold a beat and the output is stalled.
// Configuration writes take effect at once and must be made while the
// pipe is empty.
module disk_block_to_chs_mapper_top #(
  parameter int unsigned DRIVES = dbc_pkg::DRIVES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [dbc_pkg::MAP_W-1:0]     cfg_data_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dbc_pkg::DRV_W-1:0]     drive_unit_i,
  input  wire logic [dbc_pkg::PART_W-1:0]    partition_i,
  input  wire logic [dbc_pkg::BLK_W-1:0]     block_number_i,
  input  wire logic [dbc_pkg::BYTES_W-1:0]   byte_count_i,
  input  wire logic [dbc_pkg::CCYL_W-1:0]    current_cylinder_i,
  input  wire logic [dbc_pkg::LOOK_W-1:0]    lookahead_raw_i,
  input  wire logic                          drive_online_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [dbc_pkg::CYL_W-1:0]          cylinder_o,
  output logic [dbc_pkg::TRK_W-1:0]          track_o,
  output logic [dbc_pkg::SEC_W-1:0]          sector_o,
  output logic [dbc_pkg::SEC_W-1:0]          search_sector_o,
  output logic [1:0]                         position_action_o
);

  localparam int unsigned NST = dbc_pkg::STAGES;

  // config registers; the map keeps only the bits of drives that exist
  logic [2*DRIVES-1:0]          type_map_q;
  logic                         seek_only_q;
  logic [dbc_pkg::DIST_W-1:0]   sdist_q;
  logic [dbc_pkg::DIST_W-1:0]   margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_map_q  <= '0;
      seek_only_q <= 1'b0;
      sdist_q     <= dbc_pkg::SDIST_RST;
      margin_q    <= dbc_pkg::MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (dbc_pkg::cfg_idx_e'(cfg_idx_i))
        dbc_pkg::CFG_TYPE_MAP:    type_map_q  <= cfg_data_i[2*DRIVES-1:0];
        dbc_pkg::CFG_SEEK_ONLY:   seek_only_q <= cfg_data_i[0];
        dbc_pkg::CFG_SEARCH_DIST: sdist_q     <= cfg_data_i[dbc_pkg::DIST_W-1:0];
        dbc_pkg::CFG_ROT_MARGIN:  margin_q    <= cfg_data_i[dbc_pkg::DIST_W-1:0];
      endcase
    end
  end

  // stage valids; a stage loads when it is empty or its successor moves
  logic [NST-1:0] vld_q, vld_d, vld_in, en;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || !out_stall_i;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_in = {vld_q[NST-2:0], in_valid_i};
    vld_d  = (vld_in & en) | (vld_q & ~en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NST-1];

  dbc_pkg::chk_t chk;
  dbc_pkg::chs_t chs;

  dbc_check #(
    .DRIVES (DRIVES)
  ) u_check (
    .clk_i              (clk_i),
    .en_i               (en[0]),
    .type_map_i         (type_map_q),
    .drive_unit_i       (drive_unit_i),
    .partition_i        (partition_i),
    .block_number_i     (block_number_i),
    .byte_count_i       (byte_count_i),
    .current_cylinder_i (current_cylinder_i),
    .lookahead_raw_i    (lookahead_raw_i),
    .drive_online_i     (drive_online_i),
    .chk_o              (chk)
  );

  dbc_chs u_chs (
    .clk_i (clk_i),
    .en_i  (en[4:1]),
    .chk_i (chk),
    .chs_o (chs)
  );

  dbc_position u_position (
    .clk_i             (clk_i),
    .en_i              (en[6:5]),
    .chs_i             (chs),
    .seek_only_i       (seek_only_q),
    .search_distance_i (sdist_q),
    .rotation_margin_i (margin_q),
    .status_o          (status_o),
    .cylinder_o        (cylinder_o),
    .track_o           (track_o),
    .sector_o          (sector_o),
    .search_sector_o   (search_sector_o),
    .position_action_o (position_action_o)
  );

endmodule

`default_nettype wire

// ----- src/dbc_checker.sv -----
`default_nettype none

module dbc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [1:0]                  status_o,
  input wire logic [dbc_pkg::CYL_W-1:0]   cylinder_o,
  input wire logic [dbc_pkg::TRK_W-1:0]   track_o,
  input wire logic [dbc_pkg::SEC_W-1:0]   sector_o,
  input wire logic [dbc_pkg::SEC_W-1:0]   search_sector_o,
  input wire logic [1:0]                  position_action_o
);

  // rejected requests carry an all-zero mapping
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dbc_pkg::ST_OK |->
      cylinder_o == '0 && track_o == '0 && sector_o == '0 &&
      search_sector_o == '0 && position_action_o == dbc_pkg::ACT_NONE)
    else $error("rejected result with nonzero mapping");

  // with an empty result register the pipe can always take a beat
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(cylinder_o) && $stable(track_o) && $stable(sector_o) &&
      $stable(search_sector_o) && $stable(position_action_o))
    else $error("stalled result changed");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind disk_block_to_chs_mapper_top dbc_checker u_dbc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .cylinder_o        (cylinder_o),
  .track_o           (track_o),
  .sector_o          (sector_o),
  .search_sector_o   (search_sector_o),
  .position_action_o (position_action_o)
);

`default_nettype wire
